// ===== rtl/source_text_tokenizer_core_macros.svh =====
// assertion macros shared by the tokenizer checkers
`ifndef SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define STT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Token kinds, keyword table and shared types of the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int NAME_CHARS = 8;
    localparam int KW_COUNT   = 14;

    // token kinds
    localparam logic [5:0] KIND_NUM     = 6'd0;
    localparam logic [5:0] KIND_ID      = 6'd1;
    localparam logic [5:0] KIND_KW_BASE = 6'd2;
    localparam logic [5:0] KIND_OP_BASE = 6'd16;
    localparam logic [5:0] KIND_END     = 6'd43;
    localparam logic [5:0] KIND_ERR     = 6'd44;

    // operator index, added to the operator base kind
    localparam logic [4:0] OP_ANDAND  = 5'd0;
    localparam logic [4:0] OP_AND     = 5'd1;
    localparam logic [4:0] OP_OROR    = 5'd2;
    localparam logic [4:0] OP_OR      = 5'd3;
    localparam logic [4:0] OP_LPAREN  = 5'd4;
    localparam logic [4:0] OP_RPAREN  = 5'd5;
    localparam logic [4:0] OP_SEMI    = 5'd6;
    localparam logic [4:0] OP_PLUSEQ  = 5'd7;
    localparam logic [4:0] OP_PLUS    = 5'd8;
    localparam logic [4:0] OP_MINUSEQ = 5'd9;
    localparam logic [4:0] OP_MINUS   = 5'd10;
    localparam logic [4:0] OP_MULEQ   = 5'd11;
    localparam logic [4:0] OP_MUL     = 5'd12;
    localparam logic [4:0] OP_DIVEQ   = 5'd13;
    localparam logic [4:0] OP_DIV     = 5'd14;
    localparam logic [4:0] OP_EQEQ    = 5'd15;
    localparam logic [4:0] OP_ASSIGN  = 5'd16;
    localparam logic [4:0] OP_LE      = 5'd17;
    localparam logic [4:0] OP_SHL     = 5'd18;
    localparam logic [4:0] OP_LT      = 5'd19;
    localparam logic [4:0] OP_GE      = 5'd20;
    localparam logic [4:0] OP_SHR     = 5'd21;
    localparam logic [4:0] OP_GT      = 5'd22;
    localparam logic [4:0] OP_HASH    = 5'd23;
    localparam logic [4:0] OP_LBRACE  = 5'd24;
    localparam logic [4:0] OP_RBRACE  = 5'd25;
    localparam logic [4:0] OP_NE      = 5'd26;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // keywords packed first char in low byte
    localparam logic [63:0] KW_TEXT [0:KW_COUNT-1] = '{
        64'h0000_0000_0074_6e69,  // int
        64'h0000_0065_6c69_6877,  // while
        64'h0000_0000_0000_6f64,  // do
        64'h0000_0000_6573_6c65,  // else
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6e65_6874,  // then
        64'h0000_0066_6e61_6373,  // scanf
        64'h0000_6674_6e69_7270,  // printf
        64'h0065_6475_6c63_6e69,  // include
        64'h6d61_6572_7473_6f69,  // iostream
        64'h0000_0000_0072_6f66,  // for
        64'h0000_0000_7261_6863,  // char
        64'h0000_676e_6972_7473,  // string
        64'h0000_0000_6e69_616d   // main
    };
    localparam logic [7:0] KW_LEN [0:KW_COUNT-1] = '{
        8'd3, 8'd5, 8'd2, 8'd4, 8'd2, 8'd4, 8'd5,
        8'd6, 8'd7, 8'd8, 8'd3, 8'd4, 8'd6, 8'd4
    };

    // one token without its position
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] num;
        logic [63:0] text;
        logic [7:0]  len;
        logic [15:0] err;
    } t_tok;

    // queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // identifier or keyword kind of a finished word
    function automatic logic [5:0] word_kind(input logic [63:0] text,
                                             input logic [7:0] len);
        logic [5:0] k;
        k = KIND_ID;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
                k = KIND_KW_BASE + 6'(i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Short register queue that decouples the byte scanner from the token output.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_data,
    input  wire logic              i_pop,
    output stt_pkg::t_q_flags      o_flags,
    output logic      [WIDTH-1:0]  o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_flags.full  = (r_cnt == CW'(DEPTH));
    assign o_flags.empty = (r_cnt == '0);
    assign w_push = i_push && !o_flags.full;
    assign w_pop  = i_pop && !o_flags.empty;
    assign o_data = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Byte scanner: tracks numbers, words, pending operators and position, and
// hands zero, one or two finished tokens per byte to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
    parameter int POSITION_BITS = 16,
    parameter int ENTRY_W       = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [7:0]          i_char_code,
    input  wire logic                i_end_of_input,
    input  wire stt_pkg::t_q_flags   i_q,
    output logic                     o_full,
    output logic                     o_q_push,
    output logic [ENTRY_W-1:0]       o_q_data
);

    localparam int P = POSITION_BITS;

    typedef enum logic [1:0] {MODE_IDLE, MODE_NUM, MODE_WORD, MODE_OP} t_mode;

    t_mode        r_mode, n_mode;
    logic [30:0]  r_acc, n_acc;
    logic         r_neg, n_neg;
    logic [63:0]  r_word, n_word;
    logic [7:0]   r_len, n_len;
    logic [7:0]   r_op, n_op;
    logic [P-1:0] r_line, n_line;
    logic [P-1:0] r_col, n_col;

    logic         w_acc;
    logic [7:0]   c;
    logic         has_c, is_dig, is_alp, consumed;
    logic [34:0]  mul10;
    logic [3:0]   digit;
    logic [1:0]   v_cnt;
    stt_pkg::t_tok v_tok [2];
    logic [P-1:0] v_line [2];
    logic [P-1:0] v_col [2];
    logic [4:0]   o_idx;
    logic         o_two, o_err, o_none;
    logic [31:0]  num_val;

    function automatic logic [P-1:0] pos_inc(input logic [P-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic stt_pkg::t_tok mk_tok(input logic [5:0] kind,
                                             input logic [31:0] num,
                                             input logic [63:0] text,
                                             input logic [7:0] len,
                                             input logic [15:0] err);
        stt_pkg::t_tok t;
        t.kind = kind;
        t.num  = num;
        t.text = text;
        t.len  = len;
        t.err  = err;
        return t;
    endfunction

    assign w_acc    = i_push && !i_q.full;
    assign o_full   = i_q.full;
    assign o_q_push = w_acc && (v_cnt != 2'd0);
    assign o_q_data = {v_cnt, v_tok[0], v_line[0], v_col[0], v_tok[1], v_line[1], v_col[1]};

    assign c      = i_char_code;
    assign has_c  = !i_end_of_input;
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_alp = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    assign digit  = 4'(c - "0");
    assign mul10  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {31'd0, digit};
    assign num_val = r_neg ? (32'd0 - {1'b0, r_acc}) : {1'b0, r_acc};

    // next state and emitted tokens for one byte
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_word = r_word;
        n_len  = r_len;
        n_op   = r_op;
        n_line = r_line;
        n_col  = r_col;
        v_cnt  = 2'd0;
        v_tok[0] = '0;
        v_tok[1] = '0;
        v_line[0] = '0;
        v_line[1] = '0;
        v_col[0] = '0;
        v_col[1] = '0;
        consumed = 1'b0;
        o_idx  = stt_pkg::OP_AND;
        o_two  = 1'b0;
        o_err  = 1'b0;
        o_none = 1'b0;

        // flush or extend the token in progress
        if (r_mode == MODE_NUM) begin
            if (has_c && is_dig) begin
                n_acc = (mul10 > {4'd0, stt_pkg::NUM_MAX}) ? stt_pkg::NUM_MAX : mul10[30:0];
                n_col = pos_inc(n_col);
                consumed = 1'b1;
            end else begin
                v_tok[v_cnt[0]] = mk_tok(stt_pkg::KIND_NUM, num_val, 64'd0, 8'd0, 16'd0);
                v_line[v_cnt[0]] = n_line;
                v_col[v_cnt[0]] = n_col;
                v_cnt = v_cnt + 2'd1;
                if (r_neg) begin
                    n_col = pos_inc(n_col);
                end
                n_mode = MODE_IDLE;
                n_acc = '0;
                n_neg = 1'b0;
            end
        end else if (r_mode == MODE_WORD) begin
            if (has_c && (is_dig || is_alp)) begin
                if (r_len < 8'(stt_pkg::NAME_CHARS)) begin
                    n_word = r_word | ({56'd0, c} << {r_len[2:0], 3'b000});
                end
                if (r_len != 8'hFF) begin
                    n_len = r_len + 8'd1;
                end
                n_col = pos_inc(n_col);
                consumed = 1'b1;
            end else begin
                v_tok[v_cnt[0]] = mk_tok(stt_pkg::word_kind(r_word, r_len), 32'd0,
                                         r_word, r_len, 16'd0);
                v_line[v_cnt[0]] = n_line;
                v_col[v_cnt[0]] = n_col;
                v_cnt = v_cnt + 2'd1;
                n_mode = MODE_IDLE;
                n_word = '0;
                n_len = '0;
            end
        end else if (r_mode == MODE_OP) begin
            // resolve the pending operator against this byte
            n_mode = MODE_IDLE;
            n_op = '0;
            case (r_op)
                "&": begin
                    if (has_c && c == "&") begin
                        o_idx = stt_pkg::OP_ANDAND; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_AND;
                end
                "|": begin
                    if (has_c && c == "|") begin
                        o_idx = stt_pkg::OP_OROR; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_OR;
                end
                "+": begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_PLUSEQ; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_PLUS;
                end
                "-": begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_MINUSEQ; o_two = 1'b1;
                    end else if (has_c && is_dig) begin
                        o_none = 1'b1;
                        n_mode = MODE_NUM;
                        n_neg = 1'b1;
                        n_acc = {27'd0, digit};
                    end else o_idx = stt_pkg::OP_MINUS;
                end
                "*": begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_MULEQ; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_MUL;
                end
                "/": begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_DIVEQ; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_DIV;
                end
                "=": begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_EQEQ; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_ASSIGN;
                end
                "<": begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_LE; o_two = 1'b1;
                    end else if (has_c && c == "<") begin
                        o_idx = stt_pkg::OP_SHL; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_LT;
                end
                ">": begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_GE; o_two = 1'b1;
                    end else if (has_c && c == ">") begin
                        o_idx = stt_pkg::OP_SHR; o_two = 1'b1;
                    end else o_idx = stt_pkg::OP_GT;
                end
                default: begin
                    if (has_c && c == "=") begin
                        o_idx = stt_pkg::OP_NE; o_two = 1'b1;
                    end else o_err = 1'b1;
                end
            endcase
            consumed = o_two || o_none;
            if (!o_none) begin
                if (o_err) begin
                    v_tok[v_cnt[0]] = mk_tok(stt_pkg::KIND_ERR, 32'd0, 64'd0, 8'd0,
                                             {(has_c ? c : 8'd0), 8'h21});
                end else begin
                    v_tok[v_cnt[0]] = mk_tok(stt_pkg::KIND_OP_BASE + {1'b0, o_idx}, 32'd0,
                                             64'd0, 8'd0, 16'd0);
                end
                v_line[v_cnt[0]] = n_line;
                v_col[v_cnt[0]] = n_col;
                v_cnt = v_cnt + 2'd1;
                n_col = pos_inc(n_col);
                if (o_two) begin
                    n_col = pos_inc(n_col);
                end
            end
        end

        if (i_end_of_input) begin
            // end token, then back to the reset state
            v_tok[v_cnt[0]] = mk_tok(stt_pkg::KIND_END, 32'd0, 64'd0, 8'd0, 16'd0);
            v_line[v_cnt[0]] = n_line;
            v_col[v_cnt[0]] = n_col;
            v_cnt = v_cnt + 2'd1;
            n_mode = MODE_IDLE;
            n_acc = '0;
            n_neg = 1'b0;
            n_word = '0;
            n_len = '0;
            n_op = '0;
            n_line = P'(1);
            n_col = P'(1);
        end else if (!consumed) begin
            // byte seen in idle
            if (is_dig) begin
                n_mode = MODE_NUM;
                n_neg = 1'b0;
                n_acc = {27'd0, digit};
            end else if (is_alp) begin
                n_mode = MODE_WORD;
                n_word = {56'd0, c};
                n_len = 8'd1;
            end else begin
                case (c)
                    " ": n_col = pos_inc(n_col);
                    "\n": begin
                        n_line = pos_inc(n_line);
                        n_col = P'(1);
                    end
                    "\t", "\r": ;
                    "&", "|", "+", "-", "*", "/", "=", "<", ">", "!": begin
                        n_mode = MODE_OP;
                        n_op = c;
                    end
                    "(", ")", ";", "#", "{", "}": begin
                        case (c)
                            "(": o_idx = stt_pkg::OP_LPAREN;
                            ")": o_idx = stt_pkg::OP_RPAREN;
                            ";": o_idx = stt_pkg::OP_SEMI;
                            "#": o_idx = stt_pkg::OP_HASH;
                            "{": o_idx = stt_pkg::OP_LBRACE;
                            default: o_idx = stt_pkg::OP_RBRACE;
                        endcase
                        v_tok[v_cnt[0]] = mk_tok(stt_pkg::KIND_OP_BASE + {1'b0, o_idx}, 32'd0,
                                                 64'd0, 8'd0, 16'd0);
                        v_line[v_cnt[0]] = n_line;
                        v_col[v_cnt[0]] = n_col;
                        v_cnt = v_cnt + 2'd1;
                        n_col = pos_inc(n_col);
                    end
                    default: begin
                        v_tok[v_cnt[0]] = mk_tok(stt_pkg::KIND_ERR, 32'd0, 64'd0, 8'd0,
                                                 {8'd0, c});
                        v_line[v_cnt[0]] = n_line;
                        v_col[v_cnt[0]] = n_col;
                        v_cnt = v_cnt + 2'd1;
                        n_col = pos_inc(n_col);
                    end
                endcase
            end
        end
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_word <= '0;
            r_len  <= '0;
            r_op   <= '0;
            r_line <= P'(1);
            r_col  <= P'(1);
        end else if (w_acc) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_word <= n_word;
            r_len  <= n_len;
            r_op   <= n_op;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Token issue: splits queue entries into single tokens and holds the oldest
// one in the result register until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back #(
    parameter int POSITION_BITS = 16,
    parameter int ENTRY_W       = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire stt_pkg::t_q_flags        i_q,
    input  wire logic [ENTRY_W-1:0]       i_q_data,
    output logic                          o_q_pop,
    input  wire logic                     i_pop,
    output logic                          o_empty,
    output logic [5:0]                    o_token_kind,
    output logic signed [31:0]            o_number_value,
    output logic [63:0]                   o_name_text,
    output logic [7:0]                    o_name_length,
    output logic [POSITION_BITS-1:0]      o_line_number,
    output logic [POSITION_BITS-1:0]      o_column_number,
    output logic [15:0]                   o_error_chars,
    output logic                          o_last_of_run
);

    localparam int P      = POSITION_BITS;
    localparam int TOK_W  = $bits(stt_pkg::t_tok);
    localparam int SLOT_W = TOK_W + 2 * P;

    logic                r_vld, r_phase, r_last;
    stt_pkg::t_tok       r_tok;
    logic [P-1:0]        r_line, r_col;
    logic [1:0]          q_cnt;
    logic [SLOT_W-1:0]   slot;
    logic                load, sel_last;

    assign q_cnt    = i_q_data[2*SLOT_W+1 : 2*SLOT_W];
    assign slot     = r_phase ? i_q_data[SLOT_W-1:0] : i_q_data[2*SLOT_W-1 : SLOT_W];
    assign sel_last = r_phase || (q_cnt == 2'd1);
    assign load     = !r_vld || i_pop;
    assign o_q_pop  = load && !i_q.empty && sel_last;

    // result register and entry phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_vld <= !i_q.empty;
            if (!i_q.empty) begin
                r_phase <= !sel_last;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load && !i_q.empty) begin
            r_tok  <= slot[SLOT_W-1 : 2*P];
            r_line <= slot[2*P-1 : P];
            r_col  <= slot[P-1:0];
            r_last <= sel_last;
        end
    end

    assign o_empty         = !r_vld;
    assign o_token_kind    = r_tok.kind;
    assign o_number_value  = $signed(r_tok.num);
    assign o_name_text     = r_tok.text;
    assign o_name_length   = r_tok.len;
    assign o_line_number   = r_line;
    assign o_column_number = r_col;
    assign o_error_chars   = r_tok.err;
    assign o_last_of_run   = r_last;

endmodule

`default_nettype wire

// ===== rtl/source_text_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming tokenizer: one source byte in, tokens with line and column out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle as long as its token queue
// (QUEUE_DEPTH entries, one per byte that yields tokens) has room. A byte
// yields up to two tokens; the result side issues one token per cycle while
// tokens are popped, and the queue absorbs the bursts of bytes with two
// tokens. The first token of a byte reaches the result ports through the
// queue and the result register: the scanner is combinational and writes the
// queue at the accepting edge, and the result register loads from the queue
// when it is empty or being popped. Tokens are held until popped and come out
// in source order.
`default_nettype none

module source_text_tokenizer_core #(
    parameter int POSITION_BITS = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [7:0]               i_char_code,
    input  wire logic                     i_end_of_input,
    output logic                          empty,
    input  wire logic                     pop,
    output logic [5:0]                    o_token_kind,
    output logic signed [31:0]            o_number_value,
    output logic [63:0]                   o_name_text,
    output logic [7:0]                    o_name_length,
    output logic [POSITION_BITS-1:0]      o_line_number,
    output logic [POSITION_BITS-1:0]      o_column_number,
    output logic [15:0]                   o_error_chars,
    output logic                          o_last_of_run
);

    localparam int ENTRY_W = 2 + 2 * ($bits(stt_pkg::t_tok) + 2 * POSITION_BITS);

    stt_pkg::t_q_flags  q_flags;
    logic               q_push, q_pop;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    // byte scanner
    stt_front #(.POSITION_BITS(POSITION_BITS), .ENTRY_W(ENTRY_W)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .i_q            (q_flags),
        .o_full         (full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    // token queue
    stt_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_flags (q_flags),
        .o_data  (q_rdata)
    );

    // token issue
    stt_back #(.POSITION_BITS(POSITION_BITS), .ENTRY_W(ENTRY_W)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q             (q_flags),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_token_kind    (o_token_kind),
        .o_number_value  (o_number_value),
        .o_name_text     (o_name_text),
        .o_name_length   (o_name_length),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_error_chars   (o_error_chars),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== rtl/stt_checker.sv =====
// ----------------------------------------------------------------------------
// stt_checker
// Port level checks of the tokenizer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_text_tokenizer_core_macros.svh"

module stt_checker #(
    parameter int POSITION_BITS = 16
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     full,
    input wire logic                     empty,
    input wire logic                     pop,
    input wire logic [5:0]               o_token_kind,
    input wire logic signed [31:0]       o_number_value,
    input wire logic [POSITION_BITS-1:0] o_line_number,
    input wire logic                     o_last_of_run
);

    // nothing waits and room is free right after reset
    `STT_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (empty && !full), "not clear after reset")

    // a waiting result holds until popped
    `STT_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_token_kind) && $stable(o_number_value) && $stable(o_line_number)), "result changed while waiting")

    // the end token always closes its run
    `STT_ASSERT(a_end_last, i_clk, i_rst_n, (!empty && o_token_kind == stt_pkg::KIND_END) |-> o_last_of_run, "end token not last of run")

    // only number tokens carry a value
    `STT_ASSERT(a_num_zero, i_clk, i_rst_n, (!empty && o_token_kind != stt_pkg::KIND_NUM) |-> (o_number_value == 32'sd0), "value on non-number token")

endmodule

bind source_text_tokenizer_core stt_checker #(.POSITION_BITS(POSITION_BITS)) u_stt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_token_kind   (o_token_kind),
    .o_number_value (o_number_value),
    .o_line_number  (o_line_number),
    .o_last_of_run  (o_last_of_run)
);

`default_nettype wire
